### rtl/core/idll_pkg.sv
`default_nettype none

package idll_pkg;

  // Default table depth, and the fixed widths of the item fields.
  localparam int ENTRIES_DEF = 64;
  localparam int ID_W        = 6;
  localparam int OP_W        = 2;
  localparam int ST_W        = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_WALK   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_ABSENT = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE  = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [ID_W-1:0] anchor_id;
    logic            side;
    logic [ID_W-1:0] remove_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] entry_id;
    logic [ST_W-1:0] status;
    logic            last;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/idll_link_mem.sv
`default_nettype none

module idll_link_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [AW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] wr_data
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] q;
  // Entries 0 and 1 keep their reset links until first written; the head and
  // entry 1 point at each other, so a fresh read gives 1 for the head and 0
  // for entry 1.
  logic [1:0]    fresh;
  logic          q_fresh;
  logic          q_head;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q      <= mem[rd_addr];
      q_head <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh   <= 2'b11;
      q_fresh <= 1'b0;
    end else begin
      if (wr_en && (wr_addr < AW'(2))) begin
        fresh[wr_addr[0]] <= 1'b0;
      end
      if (rd_en) begin
        q_fresh <= (rd_addr < AW'(2)) && fresh[rd_addr[0]];
      end
    end
  end

  assign rd_data = q_fresh ? (q_head ? AW'(1) : '0) : q;

endmodule

`default_nettype wire

### rtl/core/indexed_doubly_linked_list.sv
`default_nettype none

// Ordered list of numbered entries kept in two link tables (left and right),
// threaded as a circle through entry 0, the head. After reset the list holds
// only entry 1 and the next number to hand out is 2.
// Input channel: in_valid / in_stall / in_data. An insert transaction links the
// next number beside an anchor entry, a remove transaction marks an entry as
// removed, and a walk transaction lists every unremoved entry from head to
// tail. Output channel: out_valid / out_stall / out_data, one transaction per
// result, with last set on the final result of each input transaction.
// The block works on one input transaction at a time. A remove, an error reply
// or an unused opcode is done on acceptance; an insert makes one link read and
// two writes, bounded by the single write port of each link memory; a walk
// reads one linked entry at a time, paced by the read latency of the right
// link and mark memories, and each removed entry ahead of its first result
// delays that result.
// A result sits in the output register until it is taken; while the receiver
// stalls, a walk pauses when it has a result to emit, and new input is held off.
// Reset is synchronous; no memory sweep is needed.
module indexed_doubly_linked_list #(
  parameter int ENTRIES = idll_pkg::ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire idll_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output idll_pkg::out_item_t      out_data
);

  import idll_pkg::*;

  // Entry numbers must fit the 6-bit fields, so the table stops at 64.
  localparam int CAP = (ENTRIES < 64) ? ENTRIES : 64;
  localparam int IW  = $clog2(CAP);
  localparam int XW  = ID_W + 1;
  localparam logic [XW-1:0] CAP_X = XW'(CAP);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_WR   = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_WALK_END = 3'd4;

  logic [2:0]    state, state_next;
  logic [IW:0]   next_entry;
  logic          side_q;
  logic [IW-1:0] anchor_q;
  logic [IW-1:0] nb_q, nb_next;
  logic [IW-1:0] pend_id, pend_id_next;
  logic          have_pend, have_pend_next;
  logic [IW-1:0] walk_id, walk_id_next;

  logic          accept;
  logic          can_emit;
  logic          emit;
  out_item_t     emit_data;
  logic          bump_entry;

  // Link memory ports. The near table is the one on the insert side.
  logic          lm_rd_en, rm_rd_en;
  logic [IW-1:0] lm_rd_addr, rm_rd_addr;
  logic [IW-1:0] lm_q, rm_q;
  logic          w_en;
  logic [IW-1:0] wa_near, wd_near, wa_far, wd_far;

  // Removed marks live in their own memory. An entry's mark is cleared when
  // it is inserted, before anything links to it, so only entry 1 needs a
  // fresh flag; the head's mark is never read.
  logic          mk_mem [CAP];
  logic          mk_rd_en;
  logic [IW-1:0] mk_rd_addr;
  logic          mk_q;
  logic          mk_fresh;
  logic          mk_q_fresh;
  logic          mk_removed;
  logic          mk_wr_en;
  logic [IW-1:0] mk_wr_addr;
  logic          mk_wr_data;
  logic          walk_skip;

  logic [XW-1:0] anchor_x, rid_x, next_x;
  logic [IW-1:0] k;
  logic [IW-1:0] cur;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign can_emit = !out_valid || !out_stall;

  assign anchor_x = XW'(in_data.anchor_id);
  assign rid_x    = XW'(in_data.remove_id);
  assign next_x   = XW'(next_entry);
  assign k        = next_entry[IW-1:0];
  assign cur      = rm_q;

  // During a walk, walk_id is the entry whose right link (cur) and removed
  // mark have just come back from the memories. The head is never listed.
  assign mk_removed = mk_q && !mk_q_fresh;
  assign walk_skip  = (walk_id == '0) ? 1'b1 : mk_removed;

  always_comb begin
    state_next     = state;
    nb_next        = nb_q;
    pend_id_next   = pend_id;
    have_pend_next = have_pend;
    walk_id_next   = walk_id;
    emit           = 1'b0;
    emit_data      = '{entry_id: '0, status: ST_OK, last: 1'b1};
    bump_entry     = 1'b0;
    lm_rd_en       = 1'b0;
    rm_rd_en       = 1'b0;
    lm_rd_addr     = in_data.anchor_id[IW-1:0];
    rm_rd_addr     = in_data.anchor_id[IW-1:0];
    mk_rd_en       = 1'b0;
    mk_rd_addr     = cur;
    mk_wr_en       = 1'b0;
    mk_wr_addr     = k;
    mk_wr_data     = 1'b0;
    w_en           = 1'b0;
    wa_near        = k;
    wd_near        = k;
    wa_far         = k;
    wd_far         = k;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_INSERT: begin
              if (anchor_x >= CAP_X) begin
                emit             = 1'b1;
                emit_data.status = ST_RANGE;
              end else if (anchor_x >= next_x) begin
                emit             = 1'b1;
                emit_data.status = ST_ABSENT;
              end else if (next_x >= CAP_X) begin
                emit             = 1'b1;
                emit_data.status = ST_FULL;
              end else begin
                // Fetch the anchor's neighbor on the insert side.
                lm_rd_en   = !in_data.side;
                rm_rd_en   = in_data.side;
                state_next = S_INS_RD;
              end
            end
            OP_REMOVE: begin
              if ((rid_x == '0) || (rid_x >= CAP_X)) begin
                emit             = 1'b1;
                emit_data.status = ST_RANGE;
              end else if (rid_x >= next_x) begin
                emit             = 1'b1;
                emit_data.status = ST_ABSENT;
              end else begin
                mk_wr_en           = 1'b1;
                mk_wr_addr         = in_data.remove_id[IW-1:0];
                mk_wr_data         = 1'b1;
                emit               = 1'b1;
                emit_data.entry_id = in_data.remove_id;
              end
            end
            OP_WALK: begin
              rm_rd_en       = 1'b1;
              rm_rd_addr     = '0;
              walk_id_next   = '0;
              have_pend_next = 1'b0;
              state_next     = S_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_RD: begin
        // The new entry points at the neighbor (near side) and the anchor,
        // and starts out unremoved.
        nb_next    = side_q ? rm_q : lm_q;
        w_en       = 1'b1;
        wa_near    = k;
        wd_near    = nb_next;
        wa_far     = k;
        wd_far     = anchor_q;
        mk_wr_en   = 1'b1;
        mk_wr_addr = k;
        mk_wr_data = 1'b0;
        state_next = S_INS_WR;
      end

      S_INS_WR: begin
        // The anchor and the neighbor now point at the new entry.
        w_en               = 1'b1;
        wa_near            = anchor_q;
        wd_near            = k;
        wa_far             = nb_q;
        wd_far             = k;
        emit               = 1'b1;
        emit_data.entry_id = ID_W'(k);
        bump_entry         = 1'b1;
        state_next         = S_IDLE;
      end

      S_WALK: begin
        // One result is held back so that the final one can carry last.
        // The walk waits only when a listed entry meets a full output.
        if (walk_skip || !have_pend || can_emit) begin
          if (!walk_skip) begin
            if (have_pend) begin
              emit               = 1'b1;
              emit_data.entry_id = ID_W'(pend_id);
              emit_data.last     = 1'b0;
            end
            pend_id_next   = walk_id;
            have_pend_next = 1'b1;
          end
          if (cur == '0) begin
            state_next = S_WALK_END;
          end else begin
            rm_rd_en     = 1'b1;
            rm_rd_addr   = cur;
            mk_rd_en     = 1'b1;
            mk_rd_addr   = cur;
            walk_id_next = cur;
          end
        end
      end

      S_WALK_END: begin
        if (can_emit) begin
          emit = 1'b1;
          if (have_pend) begin
            emit_data.entry_id = ID_W'(pend_id);
          end else begin
            emit_data.status = ST_EMPTY;
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_entry <= (IW + 1)'(2);
      have_pend  <= 1'b0;
      out_valid  <= 1'b0;
      mk_fresh   <= 1'b1;
      mk_q_fresh <= 1'b0;
    end else begin
      state     <= state_next;
      have_pend <= have_pend_next;
      if (bump_entry) begin
        next_entry <= next_entry + 1'b1;
      end
      if (mk_wr_en && (mk_wr_addr == IW'(1))) begin
        mk_fresh <= 1'b0;
      end
      if (mk_rd_en) begin
        mk_q_fresh <= (mk_rd_addr == IW'(1)) && mk_fresh;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mk_wr_en) begin
      mk_mem[mk_wr_addr] <= mk_wr_data;
    end
    if (mk_rd_en) begin
      mk_q <= mk_mem[mk_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      side_q   <= in_data.side;
      anchor_q <= in_data.anchor_id[IW-1:0];
    end
    nb_q    <= nb_next;
    pend_id <= pend_id_next;
    walk_id <= walk_id_next;
    if (emit) begin
      out_data <= emit_data;
    end
  end

  idll_link_mem #(
    .DEPTH (CAP),
    .AW    (IW)
  ) u_left (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (lm_rd_en),
    .rd_addr (lm_rd_addr),
    .rd_data (lm_q),
    .wr_en   (w_en),
    .wr_addr (side_q ? wa_far : wa_near),
    .wr_data (side_q ? wd_far : wd_near)
  );

  idll_link_mem #(
    .DEPTH (CAP),
    .AW    (IW)
  ) u_right (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rm_rd_en),
    .rd_addr (rm_rd_addr),
    .rd_data (rm_q),
    .wr_en   (w_en),
    .wr_addr (side_q ? wa_near : wa_far),
    .wr_data (side_q ? wd_near : wd_far)
  );

`ifndef NO_ASSERTIONS
  // The output register must be free when a new result is loaded.
  assert property (@(posedge clk) disable iff (rst) emit |-> can_emit)
    else $error("result overwrote an untaken output transaction");

  // An insert relies on the output register having drained at acceptance.
  assert property (@(posedge clk) disable iff (rst) (state == S_INS_WR) |-> !out_valid)
    else $error("output register busy at insert completion");

  // A successful result never names the head.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ST_OK)) |-> (out_data.entry_id != '0))
    else $error("head entry reported as a list member");

  // Entry numbers are never handed out beyond the table.
  assert property (@(posedge clk) disable iff (rst) next_x <= CAP_X)
    else $error("next entry number ran past the table");
`endif

endmodule

`default_nettype wire

### tb/idll_checker.sv
`timescale 1ns / 100ps

module idll_checker #(
  parameter int ENTRIES = idll_pkg::ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire idll_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire idll_pkg::out_item_t out_data,
  output int                       errors,
  output int                       pending,
  output int                       checked
);

  import idll_pkg::*;

  localparam int CAP = (ENTRIES < 64) ? ENTRIES : 64;

  // Shadow copy of the list: links, presence and removal marks, next number.
  logic [ID_W-1:0] left_of [CAP];
  logic [ID_W-1:0] right_of [CAP];
  bit              linked [CAP];
  bit              gone [CAP];
  int unsigned     next_num;

  out_item_t list_replies[$];
  int        err_count = 0;
  int        seen_count = 0;

  assign errors  = err_count;
  assign checked = seen_count;

  task automatic clear_list();
    for (int i = 0; i < CAP; i++) begin
      left_of[i]  = '0;
      right_of[i] = '0;
      linked[i]   = 1'b0;
      gone[i]     = 1'b0;
    end
    left_of[0]  = ID_W'(1);
    right_of[0] = ID_W'(1);
    linked[0]   = 1'b1;
    linked[1]   = 1'b1;
    next_num    = 2;
    list_replies.delete();
  endtask

  task automatic push_reply(input int id, input logic [ST_W-1:0] st, input logic lst);
    out_item_t r;
    r.entry_id = ID_W'(id);
    r.status   = st;
    r.last     = lst;
    list_replies.push_back(r);
  endtask

  task automatic predict_reply(input in_item_t it);
    int        k;
    int        nb;
    int        cur;
    int        guard;
    int        found;
    int        a;
    int        rid;
    out_item_t tail;
    a   = int'(it.anchor_id);
    rid = int'(it.remove_id);
    case (it.opcode)
      OP_INSERT: begin
        if (a >= CAP) begin
          push_reply(0, ST_RANGE, 1'b1);
        end else if (!linked[a]) begin
          push_reply(0, ST_ABSENT, 1'b1);
        end else if (next_num >= CAP) begin
          push_reply(0, ST_FULL, 1'b1);
        end else begin
          k = int'(next_num);
          if (it.side) begin
            nb = int'(right_of[a]);
            right_of[k] = ID_W'(nb);
            left_of[k]  = ID_W'(a);
            right_of[a] = ID_W'(k);
            left_of[nb] = ID_W'(k);
          end else begin
            nb = int'(left_of[a]);
            left_of[k]   = ID_W'(nb);
            right_of[k]  = ID_W'(a);
            left_of[a]   = ID_W'(k);
            right_of[nb] = ID_W'(k);
          end
          linked[k] = 1'b1;
          gone[k]   = 1'b0;
          next_num  = k + 1;
          push_reply(k, ST_OK, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (rid == 0 || rid >= CAP) begin
          push_reply(0, ST_RANGE, 1'b1);
        end else if (!linked[rid]) begin
          push_reply(0, ST_ABSENT, 1'b1);
        end else begin
          gone[rid] = 1'b1;
          push_reply(rid, ST_OK, 1'b1);
        end
      end
      OP_WALK: begin
        found = 0;
        guard = 0;
        cur   = int'(right_of[0]);
        while (cur != 0 && cur < CAP && guard < CAP) begin
          if (!gone[cur]) begin
            push_reply(cur, ST_OK, 1'b0);
            found++;
          end
          cur = int'(right_of[cur]);
          guard++;
        end
        if (found == 0) begin
          push_reply(0, ST_EMPTY, 1'b1);
        end else begin
          tail = list_replies.pop_back();
          tail.last = 1'b1;
          list_replies.push_back(tail);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_reply(input out_item_t got);
    out_item_t want;
    seen_count++;
    if (list_replies.size() == 0) begin
      report_mismatch("unexpected result transaction, entry_id", int'(got.entry_id), -1);
    end else begin
      want = list_replies.pop_front();
      if (got.entry_id !== want.entry_id)
        report_mismatch("entry_id", int'(got.entry_id), int'(want.entry_id));
      if (got.status !== want.status)
        report_mismatch("status", int'(got.status), int'(want.status));
      if (got.last !== want.last)
        report_mismatch("last", int'(got.last), int'(want.last));
    end
  endtask

  // A result taken at an edge cannot stem from an input taken at the same
  // edge, so the result is checked before the new prediction is queued.
  always @(posedge clk) begin
    if (rst) begin
      clear_list();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) check_reply(out_data);
      if (in_valid === 1'b1 && in_stall === 1'b0) predict_reply(in_data);
    end
    pending = list_replies.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import idll_pkg::*;

  // Entry numbers run from 1 to CAP-1; the block never hands out more.
  localparam int CAP = (ENTRIES_DEF < 64) ? ENTRIES_DEF : 64;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      out_stall = 1'b0;
  in_item_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int errors;
  int pending;
  int checked;

  // The stimulus side keeps just enough of the list to aim its transactions:
  // entries 0 .. next_free-1 are present, since inserts never skip numbers.
  int next_free = 2;
  int n_insert = 0;
  int n_remove = 0;
  int n_walk = 0;
  int n_ignored = 0;

  // While set, the sender offers transactions back to back with no gaps.
  bit tx_quiet = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  indexed_doubly_linked_list #(
    .ENTRIES(ENTRIES_DEF)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  idll_checker #(
    .ENTRIES(ENTRIES_DEF)
  ) chk (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  // Idle cycles before the next input transaction: mostly none or a few,
  // now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one input transaction and returns at the falling edge after it has
  // been taken. The caller then either drives the next transaction or drops
  // valid in that same step, so valid is never lowered and raised together.
  task automatic send_item(input logic [OP_W-1:0] op, input int anchor, input logic side,
                           input int rid);
    in_item_t it;
    int       gap;
    it.opcode    = op;
    it.anchor_id = ID_W'(anchor);
    it.side      = side;
    it.remove_id = ID_W'(rid);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    case (op)
      OP_INSERT: begin
        n_insert++;
        if (anchor < next_free && next_free < CAP) next_free++;
      end
      OP_REMOVE: n_remove++;
      OP_WALK:   n_walk++;
      default:   n_ignored++;
    endcase
  endtask

  // Receiver pacing: short stalls and short runs most of the time, with an
  // occasional long stall and an occasional long stretch with no stall at all.
  initial begin : rx_pacing
    int run_left;
    int r;
    bit stall_on;
    run_left = 0;
    stall_on = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          stall_on = 1'b0;
          run_left = $urandom_range(40, 150);
        end else if (r < 55) begin
          stall_on = 1'b0;
          run_left = $urandom_range(1, 6);
        end else if (r < 95) begin
          stall_on = 1'b1;
          run_left = $urandom_range(1, 3);
        end else begin
          stall_on = 1'b1;
          run_left = $urandom_range(10, 40);
        end
      end
      out_stall <= stall_on;
      run_left--;
    end
  end

  initial begin : stimulus
    int counted;
    int r;
    logic [OP_W-1:0] op;
    int anchor;
    int rid;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. From reset the list holds entry 1 alone.
    send_item(OP_WALK, $urandom_range(0, 63), 1'($urandom), $urandom_range(0, 63));
    // An anchor at the top of the field that was never inserted.
    send_item(OP_INSERT, 63, 1'b1, 63);
    // Removing the head sentinel is out of range.
    send_item(OP_REMOVE, 63, 1'b1, 0);
    // Removing an entry that was never inserted changes nothing.
    send_item(OP_REMOVE, 0, 1'b0, 63);
    send_item(OP_REMOVE, $urandom_range(0, 63), 1'($urandom), 1);
    // With entry 1 removed, a walk finds nothing to list.
    send_item(OP_WALK, 0, 1'b0, 0);
    // A second remove of the same entry is harmless.
    send_item(OP_REMOVE, 0, 1'b0, 1);
    // A removed entry still serves as an anchor.
    send_item(OP_INSERT, 1, 1'b1, 0);
    // Left of the head appends at the tail, right of the head goes first.
    send_item(OP_INSERT, 0, 1'b0, 63);
    send_item(OP_INSERT, 0, 1'b1, 0);
    send_item(OP_INSERT, 2, 1'b0, $urandom_range(0, 63));
    send_item(OP_WALK, 63, 1'b1, 63);
    // The unused opcode, with every field bit set, produces nothing.
    send_item(OP_UNUSED, 63, 1'b1, 63);
    send_item(OP_REMOVE, 63, 1'b1, 3);
    send_item(OP_INSERT, 3, 1'b1, 0);
    send_item(OP_INSERT, 50, 1'b0, 0);
    send_item(OP_WALK, 0, 1'b0, 0);

    // Random part: mostly inserts beside present entries and removes of
    // present entries, with walks mixed in, plus some stray ids and noise.
    counted = 0;
    while (counted < 150) begin
      tx_quiet = (counted % 60) >= 45;
      r = $urandom_range(0, 99);
      anchor = $urandom_range(0, 63);
      rid = $urandom_range(0, 63);
      if (r < 45) begin
        op = OP_INSERT;
        if (r < 40) anchor = $urandom_range(0, next_free - 1);
      end else if (r < 75) begin
        op = OP_REMOVE;
        if (r < 70) rid = $urandom_range(1, next_free - 1);
      end else if (r < 90) begin
        op = OP_WALK;
      end else if (r < 95) begin
        op = OP_UNUSED;
      end else begin
        op = OP_W'($urandom_range(0, 3));
      end
      send_item(op, anchor, 1'($urandom), rid);
      if (op != OP_UNUSED) counted++;
    end
    tx_quiet = 1'b0;

    // Fill the table, run into the full case, and list the whole thing.
    while (next_free < CAP)
      send_item(OP_INSERT, $urandom_range(0, next_free - 1), 1'($urandom),
                $urandom_range(0, 63));
    send_item(OP_INSERT, 0, 1'b1, 0);
    send_item(OP_INSERT, CAP - 1, 1'b0, 63);
    send_item(OP_WALK, 0, 1'b0, 0);
    send_item(OP_REMOVE, 0, 1'b0, CAP - 1);
    send_item(OP_WALK, 63, 1'b1, 63);
    in_valid <= 1'b0;

    // Let every expected result arrive, then watch a while for strays.
    wait (pending == 0);
    repeat (30) @(posedge clk);

    $display("Covered %0d inserts, %0d removes, %0d walks and %0d ignored transactions.",
             n_insert, n_remove, n_walk, n_ignored);
    $display("Compared %0d result transactions; %0d mismatches, %0d results outstanding.",
             checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
